>>> hw/rtl/word_deframer_crc8_check_top_defines.svh
// ------------------------------------------------------------------------
// Assertion macros for the word deframer with CRC-8 check
// Shared property forms, each clocked on a rising edge and disabled in reset.
// ------------------------------------------------------------------------
`ifndef WORD_DEFRAMER_CRC8_CHECK_TOP_DEFINES_SVH
`define WORD_DEFRAMER_CRC8_CHECK_TOP_DEFINES_SVH

// Same-cycle implication
`define WDC8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WDC8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wdc8_pkg.sv
// ------------------------------------------------------------------------
// wdc8_pkg
// Opcodes, status codes, result type and CRC-8 byte step for the deframer.
// ------------------------------------------------------------------------
package wdc8_pkg;

    // Request opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Transfer status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_LEN    = 2'd2;
    localparam logic [1:0] ST_NODATA = 2'd3;

    // CRC-8 parameters: polynomial 0x31, init 0xFF, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    typedef struct packed {
        logic        has_result;
        logic [15:0] data_word;
        logic        word_valid;
        logic        finished;
        logic [1:0]  status;
        logic [8:0]  received_length;
    } t_result;

    // Fold one byte into the CRC, eight shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

>>> hw/rtl/wdc8_core.sv
// ------------------------------------------------------------------------
// wdc8_core
// Transfer state and per-request result logic; state advances on i_adv.
// ------------------------------------------------------------------------
module wdc8_core
    import wdc8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_expected_bytes,
    output t_result    o_result
);

    // Bytes held of the current group
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_CHECK  = 2'd2;

    logic       r_active,   n_active;
    logic [1:0] r_phase,    n_phase;
    logic [7:0] r_first,    n_first;
    logic [7:0] r_second,   n_second;
    logic [7:0] r_crc,      n_crc;
    logic [8:0] r_length,   n_length;
    logic [7:0] r_expected, n_expected;
    logic [8:0] len_next;
    logic [8:0] total;
    t_result    res;

    // Decode the request against the transfer state
    always_comb begin
        n_active   = r_active;
        n_phase    = r_phase;
        n_first    = r_first;
        n_second   = r_second;
        n_crc      = r_crc;
        n_length   = r_length;
        n_expected = r_expected;
        len_next   = r_length + 9'd2;
        total      = r_length + {7'd0, r_phase};
        res        = '0;
        if (i_adv) begin
            case (i_opcode)
                OP_START: begin
                    n_active   = 1'b1;
                    n_phase    = PH_FIRST;
                    n_length   = '0;
                    n_expected = i_expected_bytes;
                end
                OP_BYTE: begin
                    if (r_active) begin
                        case (r_phase)
                            PH_FIRST: begin
                                n_first = i_rx_byte;
                                n_crc   = crc8_byte(CRC_INIT, i_rx_byte);
                                n_phase = PH_SECOND;
                            end
                            PH_SECOND: begin
                                n_second = i_rx_byte;
                                n_crc    = crc8_byte(r_crc, i_rx_byte);
                                n_phase  = PH_CHECK;
                            end
                            default: begin
                                n_phase = PH_FIRST;
                                res.has_result = 1'b1;
                                if (i_rx_byte != r_crc) begin
                                    // Bad check byte ends the transfer
                                    n_active            = 1'b0;
                                    res.finished        = 1'b1;
                                    res.status          = ST_CRC;
                                    res.received_length = r_length;
                                end else begin
                                    n_length            = len_next;
                                    res.word_valid      = 1'b1;
                                    res.data_word       = {r_first, r_second};
                                    res.received_length = len_next;
                                    if (len_next >= {1'b0, r_expected}) begin
                                        n_active     = 1'b0;
                                        res.finished = 1'b1;
                                        res.status   = (len_next == {1'b0, r_expected}) ?
                                                       ST_OK : ST_LEN;
                                    end
                                end
                            end
                        endcase
                    end
                end
                OP_END: begin
                    if (r_active) begin
                        n_active            = 1'b0;
                        n_phase             = PH_FIRST;
                        n_length            = total;
                        res.has_result      = 1'b1;
                        res.finished        = 1'b1;
                        res.received_length = total;
                        if (total == '0) begin
                            res.status = ST_NODATA;
                        end else if (total == {1'b0, r_expected}) begin
                            res.status = ST_OK;
                        end else begin
                            res.status = ST_LEN;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = res;

    // Hold transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_phase    <= PH_FIRST;
            r_length   <= '0;
            r_expected <= '0;
        end else begin
            r_active   <= n_active;
            r_phase    <= n_phase;
            r_length   <= n_length;
            r_expected <= n_expected;
        end
    end

    // Group bytes and running CRC
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
        r_crc    <= n_crc;
    end

endmodule

>>> hw/rtl/word_deframer_crc8_check_top.sv
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless stalled; the CRC folds each data byte.
// Input register and result register advance together whenever the result
// register is empty or being taken.
// Reset (i_rst_n low, synchronous) closes any transfer and empties both registers.
// ------------------------------------------------------------------------
// word_deframer_crc8_check_top
// Byte-stream deframer: checks CRC-8 on each two-byte group, emits words.
// ------------------------------------------------------------------------
`include "word_deframer_crc8_check_top_defines.svh"

module word_deframer_crc8_check_top
    import wdc8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_expected_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_data_word,
    output logic        o_word_valid,
    output logic        o_finished,
    output logic [1:0]  o_status,
    output logic [8:0]  o_received_length
);

    logic       r_in_valid;
    logic [1:0] r_opcode;
    logic [7:0] r_rx_byte;
    logic [7:0] r_expected_bytes;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_free;
    logic       adv;
    t_result    res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_opcode         <= i_opcode;
            r_rx_byte        <= i_rx_byte;
            r_expected_bytes <= i_expected_bytes;
        end
    end

    wdc8_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_opcode         (r_opcode),
        .i_rx_byte        (r_rx_byte),
        .i_expected_bytes (r_expected_bytes),
        .o_result         (res)
    );

    // Load the result register, drop requests without a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv && res.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_data_word       = r_out.data_word;
    assign o_word_valid      = r_out.word_valid;
    assign o_finished        = r_out.finished;
    assign o_status          = r_out.status;
    assign o_received_length = r_out.received_length;

    // Status is only reported on the closing result
    `WDC8_ASSERT_NOW(a_status_on_finish, i_clk, i_rst_n,
        o_out_valid && !o_finished, o_status == ST_OK,
        "status set on a non-final result")
    // A failed check never carries a word
    `WDC8_ASSERT_NOW(a_crc_no_word, i_clk, i_rst_n,
        o_out_valid && o_finished && o_status == ST_CRC, !o_word_valid,
        "word emitted with crc error")
    // No-data status means nothing was counted
    `WDC8_ASSERT_NOW(a_nodata_len, i_clk, i_rst_n,
        o_out_valid && o_finished && o_status == ST_NODATA,
        o_received_length == 9'd0 && !o_word_valid,
        "no-data status with nonzero length")

endmodule
